// File: sv/tape_controller_command_status_assert.svh
// ----------------------------------------------------------------------------
// tape controller assertion macros
// shared assertion forms on clk with an asynchronous active-low reset
// ----------------------------------------------------------------------------
`ifndef TAPE_CONTROLLER_COMMAND_STATUS_ASSERT_SVH
`define TAPE_CONTROLLER_COMMAND_STATUS_ASSERT_SVH

// consequent must hold in the same cycle as the antecedent
`define TCCS_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// consequent must hold in the cycle after the antecedent
`define TCCS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: sv/tccs_pkg.sv
// ----------------------------------------------------------------------------
// tape controller command/status package
// item layouts, command codes, function codes and status bit positions
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tccs_pkg;

	// command codes carried in tuser
	typedef enum logic [2:0] {
		CMD_WRITE_CMD     = 3'd0,
		CMD_READ_STATUS   = 3'd1,
		CMD_MERGE_STATUS  = 3'd2,
		CMD_START         = 3'd3,
		CMD_SET_FLAG      = 3'd4,
		CMD_OP_DONE       = 3'd5,
		CMD_ONLINE_CHANGE = 3'd6
	} cmd_t;

	// configuration register indexes
	localparam logic CFG_CONTROLLER_TYPE  = 1'b0;
	localparam logic CFG_STOP_ON_IO_ERROR = 1'b1;

	// number of transport slots held in the unit registers
	localparam int unsigned UNIT_SLOTS = 4;

	// input transaction, last field in the lowest bits
	typedef struct packed {
		logic [3:0]  pad;
		logic [3:0]  units_write_locked;
		logic [3:0]  units_online;
		logic [3:0]  units_busy;
		logic        record_odd;
		logic [3:0]  tape_result;
		logic [1:0]  unit;
		logic        hold_clear;
		logic [15:0] data;
	} in_item_t;

	// result transaction, last field in the lowest bits
	typedef struct packed {
		logic [4:0]  pad;
		logic        detach_request;
		logic        halt_request;
		logic [3:0]  cancel_mask;
		logic        start_rewind;
		logic [1:0]  start_unit;
		logic        start_valid;
		logic        cmd_flag;
		logic [15:0] read_data;
	} res_item_t;

	// transport results
	localparam logic [3:0] TR_OK    = 4'd0;
	localparam logic [3:0] TR_TMK   = 4'd1;
	localparam logic [3:0] TR_BOT   = 4'd2;
	localparam logic [3:0] TR_EOM   = 4'd3;
	localparam logic [3:0] TR_RECE  = 4'd4;
	localparam logic [3:0] TR_INVRL = 4'd5;
	localparam logic [3:0] TR_IOERR = 4'd6;
	localparam logic [3:0] TR_FMT   = 4'd7;
	localparam logic [3:0] TR_UNATT = 4'd8;
	localparam logic [3:0] TR_WRP   = 4'd9;

	// function field of the command word
	localparam logic [7:0] OP_CLEAR = 8'o110;
	localparam logic [7:0] FN_GAP   = 8'o015;
	localparam logic [7:0] FN_GFM   = 8'o215;
	localparam logic [7:0] FN_RC    = 8'o023;
	localparam logic [7:0] FN_WC    = 8'o031;
	localparam logic [7:0] FN_FSR   = 8'o003;
	localparam logic [7:0] FN_BSR   = 8'o041;
	localparam logic [7:0] FN_FSF   = 8'o203;
	localparam logic [7:0] FN_BSF   = 8'o241;
	localparam logic [7:0] FN_REW   = 8'o101;
	localparam logic [7:0] FN_RWS   = 8'o105;
	localparam logic [7:0] FN_WFM   = 8'o211;
	localparam logic [7:0] FN_RFF   = 8'o223;

	// command word bit positions
	localparam int unsigned F_MOTION  = 0;
	localparam int unsigned F_OFFLINE = 2;
	localparam int unsigned F_WRITE   = 3;
	localparam int unsigned F_REVERSE = 5;
	localparam int unsigned F_REWIND  = 6;
	localparam int unsigned F_CHSEL   = 8;

	// status word bit positions
	localparam int unsigned S_PE    = 15;
	localparam int unsigned S_ODD   = 11;
	localparam int unsigned S_REW   = 10;
	localparam int unsigned S_TBSY  = 9;
	localparam int unsigned S_BUSY  = 8;
	localparam int unsigned S_EOF   = 7;
	localparam int unsigned S_BOT   = 6;
	localparam int unsigned S_EOT   = 5;
	localparam int unsigned S_REJ   = 3;
	localparam int unsigned S_WLK   = 2;
	localparam int unsigned S_PAR   = 1;
	localparam int unsigned S_LOCAL = 0;
	localparam int unsigned S_SEL_LO = 13;

	// bits driven live on a status read rather than stored
	localparam logic [15:0] S_DYN_MASK = 16'o160000 | 16'o001000 | 16'o000004 | 16'o000001;
	localparam logic [15:0] S_BUSY_MASK = 16'o000400;
	localparam logic [15:0] S_EOF_MASK  = 16'o000200;

	// per-unit status bits
	localparam int unsigned U_BOT = 0;
	localparam int unsigned U_EOT = 1;
	localparam int unsigned U_REW = 2;
	localparam logic [2:0] U_BOT_VAL = 3'b001;
	localparam logic [2:0] U_REW_VAL = 3'b100;

	// unit select code in command word bits 12:9, highest set bit wins
	localparam logic [1:0] SEL_MAP [16] = '{
		2'd0, 2'd0, 2'd1, 2'd1, 2'd2, 2'd2, 2'd2, 2'd2,
		2'd3, 2'd3, 2'd3, 2'd3, 2'd3, 2'd3, 2'd3, 2'd3
	};

endpackage

// File: sv/tape_controller_command_status.sv
// ----------------------------------------------------------------------------
// tape controller command/status
// a transaction is registered in the input stage and then in the result stage
// throughput: one transaction per cycle, held only by a stalled result stage
// state updates are one level of bit logic between the input and result stage
// reset: status, command word, unit select and unit state cleared, flag set
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "tape_controller_command_status_assert.svh"

module tape_controller_command_status #(
	parameter int NUM_UNITS = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	// configuration write port
	input  logic        cfg_wr_en,
	input  logic        cfg_addr,
	input  logic        cfg_wdata,
	// input stream
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [39:0] s_axis_tdata,  // data, hold_clear, unit, tape_result, record_odd,
	                                   // units_busy, units_online, units_write_locked, zero pad
	input  logic [2:0]  s_axis_tuser,  // cmd
	// result stream
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata   // read_data, cmd_flag, start_valid, start_unit,
	                                   // start_rewind, cancel_mask, halt_request,
	                                   // detach_request, zero pad
);

	localparam logic [3:0] UNIT_MASK   = 4'((1 << NUM_UNITS) - 1);
	localparam logic [2:0] UNIT_LIMIT  = 3'(NUM_UNITS);

	// configuration registers
	logic controller_type_q;
	logic stop_on_io_error_q;

	// block state
	logic [15:0] ctrl_status_q;
	logic [15:0] cmd_word_q;
	logic [1:0]  sel_unit_q;
	logic [7:0]  unit_fn_q [tccs_pkg::UNIT_SLOTS];
	logic [2:0]  unit_st_q [tccs_pkg::UNIT_SLOTS];
	logic        cmd_flag_q;

	// pipeline
	logic                in_valid_s1;
	tccs_pkg::in_item_t  in_s1;
	tccs_pkg::cmd_t      cmd_s1;
	logic                out_valid_s2;
	tccs_pkg::res_item_t out_s2;
	logic                advance;

	// next state and result
	logic [15:0]         cs_d;
	logic [15:0]         cw_d;
	logic [1:0]          sel_d;
	logic [7:0]          fn_d [tccs_pkg::UNIT_SLOTS];
	logic [2:0]          st_d [tccs_pkg::UNIT_SLOTS];
	logic                flag_d;
	tccs_pkg::res_item_t res_d;

	// masked transport lines
	logic [3:0] busy_m;
	logic [3:0] online_m;
	logic [3:0] wlk_m;

	// transport result mapping
	logic [3:0]  res_c;
	logic [15:0] map_set;
	logic        map_halt;
	logic        map_bot;

	assign busy_m   = in_s1.units_busy & UNIT_MASK;
	assign online_m = in_s1.units_online & UNIT_MASK;
	assign wlk_m    = in_s1.units_write_locked & UNIT_MASK;

	// handshake: the result stage frees the input stage
	assign advance       = !out_valid_s2 || m_axis_tready;
	assign s_axis_tready = !in_valid_s1 || advance;
	assign m_axis_tvalid = out_valid_s2;
	assign m_axis_tdata  = out_s2;

	// result codes beyond write protect behave as ok
	assign res_c = (in_s1.tape_result > tccs_pkg::TR_WRP) ? tccs_pkg::TR_OK : in_s1.tape_result;

	// status bits, halt and load point raised by a transport result
	always_comb begin
		map_set  = '0;
		map_halt = 1'b0;
		map_bot  = 1'b0;
		case (res_c)
			tccs_pkg::TR_FMT, tccs_pkg::TR_UNATT: begin
				map_set[tccs_pkg::S_REJ] = 1'b1;
				map_halt = 1'b1;
			end
			tccs_pkg::TR_TMK: begin
				map_set[tccs_pkg::S_EOF] = 1'b1;
				map_set[tccs_pkg::S_ODD] = 1'b1;
			end
			tccs_pkg::TR_INVRL: begin
				map_set[tccs_pkg::S_PAR] = 1'b1;
				map_halt = 1'b1;
			end
			tccs_pkg::TR_IOERR: begin
				map_set[tccs_pkg::S_PAR] = 1'b1;
				map_halt = stop_on_io_error_q;
			end
			tccs_pkg::TR_RECE, tccs_pkg::TR_EOM: begin
				map_set[tccs_pkg::S_PAR] = 1'b1;
			end
			tccs_pkg::TR_BOT: begin
				map_bot = 1'b1;
			end
			tccs_pkg::TR_WRP: begin
				map_set[tccs_pkg::S_REJ] = 1'b1;
			end
			default: begin
			end
		endcase
	end

	// command, status and event decode for the transaction in the input stage
	always_comb begin
		logic [1:0]  chk_sel;
		logic [15:0] ust_word;
		logic [7:0]  fn;
		logic [2:0]  ust;
		logic        apply_hc;
		logic        done;
		logic        hlt;

		cs_d     = ctrl_status_q;
		cw_d     = cmd_word_q;
		sel_d    = sel_unit_q;
		fn_d     = unit_fn_q;
		st_d     = unit_st_q;
		flag_d   = cmd_flag_q;
		res_d    = '0;
		res_d.read_data = in_s1.data;
		apply_hc = 1'b0;
		done     = 1'b1;
		hlt      = 1'b0;
		chk_sel  = sel_unit_q;
		fn       = unit_fn_q[in_s1.unit];
		ust      = unit_st_q[sel_unit_q];
		ust_word = '0;
		ust_word[tccs_pkg::S_BOT] = ust[tccs_pkg::U_BOT];
		ust_word[tccs_pkg::S_EOT] = ust[tccs_pkg::U_EOT];
		ust_word[tccs_pkg::S_REW] = ust[tccs_pkg::U_REW];

		case (cmd_s1)
			// latch command word and check it against the selected transport
			tccs_pkg::CMD_WRITE_CMD: begin
				cw_d = in_s1.data;
				cs_d[tccs_pkg::S_REJ] = 1'b0;
				apply_hc = 1'b1;
				if (in_s1.data[7:0] != tccs_pkg::OP_CLEAR) begin
					if (ctrl_status_q[tccs_pkg::S_BUSY]) begin
						cs_d[tccs_pkg::S_REJ] = 1'b1;
					end else begin
						if (in_s1.data[tccs_pkg::F_CHSEL]) begin
							chk_sel = tccs_pkg::SEL_MAP[in_s1.data[12:9]];
						end
						sel_d = chk_sel;
						if ((in_s1.data[tccs_pkg::F_MOTION] && busy_m[chk_sel]) ||
						    (in_s1.data[tccs_pkg::F_REVERSE] &&
						     unit_st_q[chk_sel][tccs_pkg::U_BOT]) ||
						    (in_s1.data[tccs_pkg::F_WRITE] && wlk_m[chk_sel])) begin
							cs_d[tccs_pkg::S_REJ] = 1'b1;
						end
					end
				end
			end
			// status word from stored bits and live transport lines
			tccs_pkg::CMD_READ_STATUS, tccs_pkg::CMD_MERGE_STATUS: begin
				if (cmd_s1 == tccs_pkg::CMD_READ_STATUS) begin
					res_d.read_data = '0;
				end
				res_d.read_data = res_d.read_data |
					((ctrl_status_q | ust_word) & ~tccs_pkg::S_DYN_MASK);
				if (online_m[sel_unit_q]) begin
					if (busy_m[sel_unit_q]) res_d.read_data[tccs_pkg::S_TBSY] = 1'b1;
					if (wlk_m[sel_unit_q]) res_d.read_data[tccs_pkg::S_WLK] = 1'b1;
				end else begin
					res_d.read_data[tccs_pkg::S_TBSY]  = 1'b1;
					res_d.read_data[tccs_pkg::S_LOCAL] = 1'b1;
				end
				if (controller_type_q) begin
					res_d.read_data[tccs_pkg::S_PE] = 1'b1;
					res_d.read_data[tccs_pkg::S_SEL_LO +: 2] =
						res_d.read_data[tccs_pkg::S_SEL_LO +: 2] | sel_unit_q;
				end
				apply_hc = 1'b1;
			end
			// clear the controller or launch the latched function
			tccs_pkg::CMD_START: begin
				if (cmd_word_q[7:0] == tccs_pkg::OP_CLEAR) begin
					for (int i = 0; i < tccs_pkg::UNIT_SLOTS; i++) begin
						res_d.cancel_mask[i] = busy_m[i] & ~unit_st_q[i][tccs_pkg::U_REW];
					end
					flag_d = 1'b1;
					cs_d   = '0;
					cw_d   = '0;
				end else begin
					fn_d[sel_unit_q]   = cmd_word_q[7:0];
					res_d.start_valid  = 1'b1;
					res_d.start_unit   = sel_unit_q;
					res_d.start_rewind = cmd_word_q[tccs_pkg::F_REWIND];
					st_d[sel_unit_q]   = '0;
					cs_d               = tccs_pkg::S_BUSY_MASK;
					apply_hc           = 1'b1;
				end
			end
			tccs_pkg::CMD_SET_FLAG: begin
				flag_d   = 1'b1;
				apply_hc = 1'b1;
			end
			// transport completion
			tccs_pkg::CMD_OP_DONE: begin
				if ({1'b0, in_s1.unit} < UNIT_LIMIT) begin
					if (!online_m[in_s1.unit]) begin
						cs_d = ctrl_status_q & ~tccs_pkg::S_BUSY_MASK;
						cs_d[tccs_pkg::S_REJ] = 1'b1;
						flag_d = 1'b1;
						res_d.halt_request = stop_on_io_error_q;
					end else begin
						case (fn)
							tccs_pkg::FN_REW, tccs_pkg::FN_RWS: begin
								if (unit_st_q[in_s1.unit][tccs_pkg::U_REW]) begin
									st_d[in_s1.unit] = fn[tccs_pkg::F_OFFLINE] ?
										3'b000 : tccs_pkg::U_BOT_VAL;
									res_d.detach_request = fn[tccs_pkg::F_OFFLINE];
									done = 1'b0;
								end else begin
									st_d[in_s1.unit] = tccs_pkg::U_REW_VAL;
								end
							end
							// file mark write replaces the status with end-of-file
							tccs_pkg::FN_GFM, tccs_pkg::FN_WFM: begin
								if (map_bot) st_d[in_s1.unit] = tccs_pkg::U_BOT_VAL;
								hlt  = map_halt;
								cs_d = tccs_pkg::S_EOF_MASK;
							end
							tccs_pkg::FN_GAP: begin
							end
							tccs_pkg::FN_FSR, tccs_pkg::FN_BSR: begin
								if (map_bot) st_d[in_s1.unit] = tccs_pkg::U_BOT_VAL;
								hlt  = map_halt;
								cs_d = ctrl_status_q | map_set;
								cs_d[tccs_pkg::S_ODD] = in_s1.record_odd;
							end
							tccs_pkg::FN_FSF, tccs_pkg::FN_BSF: begin
								if (map_bot) st_d[in_s1.unit] = tccs_pkg::U_BOT_VAL;
								hlt  = map_halt;
								cs_d = ctrl_status_q | map_set;
							end
							// transfers finish unless the result halts the host
							tccs_pkg::FN_RFF, tccs_pkg::FN_RC, tccs_pkg::FN_WC: begin
								if (map_bot) st_d[in_s1.unit] = tccs_pkg::U_BOT_VAL;
								hlt  = map_halt;
								cs_d = ctrl_status_q | map_set;
								if (!map_halt) fn_d[in_s1.unit] = '0;
							end
							default: begin
							end
						endcase
						res_d.halt_request = hlt;
						if (done) begin
							flag_d = 1'b1;
							cs_d[tccs_pkg::S_BUSY] = 1'b0;
						end
					end
				end
			end
			tccs_pkg::CMD_ONLINE_CHANGE: begin
				if ({1'b0, in_s1.unit} < UNIT_LIMIT) begin
					st_d[in_s1.unit] = in_s1.record_odd ? tccs_pkg::U_BOT_VAL : 3'b000;
				end
			end
			default: begin
			end
		endcase

		if (apply_hc && in_s1.hold_clear) flag_d = 1'b0;
		res_d.cmd_flag = flag_d;
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			controller_type_q  <= 1'b0;
			stop_on_io_error_q <= 1'b1;
		end else if (cfg_wr_en) begin
			case (cfg_addr)
				tccs_pkg::CFG_CONTROLLER_TYPE:  controller_type_q  <= cfg_wdata;
				tccs_pkg::CFG_STOP_ON_IO_ERROR: stop_on_io_error_q <= cfg_wdata;
				default: begin
				end
			endcase
		end
	end

	// input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			in_valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			in_s1  <= tccs_pkg::in_item_t'(s_axis_tdata);
			cmd_s1 <= tccs_pkg::cmd_t'(s_axis_tuser);
		end
	end

	// result stage and state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_s2  <= 1'b0;
			ctrl_status_q <= '0;
			cmd_word_q    <= '0;
			sel_unit_q    <= '0;
			cmd_flag_q    <= 1'b1;
			for (int i = 0; i < tccs_pkg::UNIT_SLOTS; i++) begin
				unit_fn_q[i] <= '0;
				unit_st_q[i] <= '0;
			end
		end else if (advance) begin
			out_valid_s2 <= in_valid_s1;
			if (in_valid_s1) begin
				ctrl_status_q <= cs_d;
				cmd_word_q    <= cw_d;
				sel_unit_q    <= sel_d;
				cmd_flag_q    <= flag_d;
				unit_fn_q     <= fn_d;
				unit_st_q     <= st_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance && in_valid_s1) begin
			out_s2 <= res_d;
		end
	end

	// checks
	`TCCS_ASSERT_SAME(a_start_no_cancel, out_valid_s2 && out_s2.start_valid, out_s2.cancel_mask == 4'b0000, "launch and clear in one result")
	`TCCS_ASSERT_SAME(a_detach_no_halt, out_valid_s2 && out_s2.detach_request, !out_s2.halt_request && !out_s2.start_valid, "detach with halt or launch")
	`TCCS_ASSERT_SAME(a_stall_only_full, !s_axis_tready, in_valid_s1 && out_valid_s2 && !m_axis_tready, "input stalled without full pipeline")
	`TCCS_ASSERT_NEXT(a_launch_busy, advance && in_valid_s1 && res_d.start_valid, ctrl_status_q == tccs_pkg::S_BUSY_MASK, "launch left status other than busy")

endmodule
